// ----- src/gam_pkg.sv -----
// ----------------------------------------------------------------------------
// gam_pkg: shared constants and types for the glucose absorption step
// History depth, index widths and the control bundle into the convolution unit.
// ----------------------------------------------------------------------------
package gam_pkg;

    // Number of kernel taps and stored intakes
    localparam int KERNEL_TAPS = 300;
    // Slot index into the intake ring
    localparam int PTR_W = $clog2(KERNEL_TAPS);
    // Counter that can also hold KERNEL_TAPS itself
    localparam int CNT_W = $clog2(KERNEL_TAPS + 1);

    // Q16.16 / Q0.32 word width
    localparam int DATA_W = 32;

    // Control from the sequencer into the convolution unit
    typedef struct packed {
        logic load;   // store a new intake and restart the sum
        logic start;  // first sample of a record: forget the history
        logic issue;  // issue one tap of the multiply-accumulate
    } t_mac_ctl;

endpackage

// ----- src/gam_mac.sv -----
// ----------------------------------------------------------------------------
// gam_mac: intake history ring and tap-by-tap convolution
// One tap per issue cycle: memory read, intake*tap product, then accumulate.
// The kernel tap decays by decay_ratio on each issued tap. Entries older than the
// start of the record are masked by a fill count.
// ----------------------------------------------------------------------------
module gam_mac import gam_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mac_ctl          i_ctl,
    input  logic [DATA_W-1:0] i_intake,
    input  logic [DATA_W-1:0] i_kernel_first,
    input  logic [DATA_W-1:0] i_decay_ratio,
    output logic              o_last_tap,   // current issue is the final tap
    output logic [DATA_W-1:0] o_rate        // saturated convolution sum
);

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(KERNEL_TAPS - 1);
    localparam logic [CNT_W-1:0] LAST_TAP  = CNT_W'(KERNEL_TAPS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(KERNEL_TAPS);

    // History memory
    logic [DATA_W-1:0] r_mem [KERNEL_TAPS];
    logic [DATA_W-1:0] r_rd_data;

    logic [PTR_W-1:0]  r_ptr, n_ptr;     // next write slot
    logic [PTR_W-1:0]  r_pos, n_pos;     // read slot of the tap being issued
    logic [CNT_W-1:0]  r_fill, n_fill;   // valid entries since record start
    logic [CNT_W-1:0]  r_cnt, n_cnt;     // tap counter
    logic [DATA_W-1:0] r_tap, n_tap;     // current kernel tap
    logic [PTR_W-1:0]  wptr;

    logic              r_vld_b, r_vld_c;
    logic [DATA_W-1:0] r_tap_b;
    logic [47:0]       r_term;
    logic [DATA_W-1:0] r_acc;
    logic              r_acc_sat;

    logic [63:0]       tap_prod;
    logic [63:0]       term_prod;
    logic [DATA_W:0]   acc_sum;

    assign wptr       = i_ctl.start ? '0 : r_ptr;
    assign tap_prod   = r_tap * i_decay_ratio;
    assign term_prod  = r_rd_data * r_tap_b;
    assign acc_sum    = {1'b0, r_acc} + {1'b0, r_term[DATA_W-1:0]};
    assign o_last_tap = (r_cnt == LAST_TAP);
    assign o_rate     = r_acc_sat ? '1 : r_acc;

    // Pointer, fill count, tap counter and kernel tap
    always_comb begin
        n_ptr  = r_ptr;
        n_pos  = r_pos;
        n_fill = r_fill;
        n_cnt  = r_cnt;
        n_tap  = r_tap;
        if (i_ctl.load) begin
            n_ptr  = (wptr == LAST_SLOT) ? '0 : wptr + PTR_W'(1);
            n_pos  = wptr;
            n_fill = i_ctl.start ? CNT_W'(1) :
                     (r_fill == FULL_CNT) ? r_fill : r_fill + CNT_W'(1);
            n_cnt  = '0;
            n_tap  = i_kernel_first;
        end else if (i_ctl.issue) begin
            n_pos  = (r_pos == '0) ? LAST_SLOT : r_pos - PTR_W'(1);
            n_cnt  = r_cnt + CNT_W'(1);
            n_tap  = tap_prod[63:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_fill  <= '0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
        end else begin
            r_ptr   <= n_ptr;
            r_fill  <= n_fill;
            r_vld_b <= i_ctl.issue && (r_cnt < r_fill);
            r_vld_c <= r_vld_b;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_cnt   <= n_cnt;
        r_tap   <= n_tap;
        r_tap_b <= r_tap;
        r_term  <= term_prod[63:16];
        if (i_ctl.load) begin
            r_acc     <= '0;
            r_acc_sat <= 1'b0;
        end else if (r_vld_c) begin
            r_acc     <= acc_sum[DATA_W-1:0];
            r_acc_sat <= r_acc_sat || acc_sum[DATA_W] || (|r_term[47:DATA_W]);
        end
    end

    // Memory write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mem[wptr] <= i_intake;
        end
    end

    // Memory read port, registered
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_pos];
    end

endmodule

// ----- src/glucose_absorption_model_step.sv -----
// ----------------------------------------------------------------------------
// glucose_absorption_model_step: meal absorption step, microcoded
// A new input beat is accepted only once the previous result has left the
// output step; the 300-tap multiply-accumulate loop over the single-read
// history memory sets the pace.
// A stalled result holds the sequencer in its output step. Reset clears the
// sequencer, loads register defaults and treats the next beat as a record start.
// ----------------------------------------------------------------------------
module glucose_absorption_model_step import gam_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] carb_intake
    input  logic [0:0]  s_axis_tuser,   // [0] restart_record
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata    // [31:0] appearance_rate, [63:32] gut_amount,
                                        // [95:64] meal_input_rate
);

    // Register indexes
    localparam logic [1:0] CFG_INV_PEAK     = 2'd0;
    localparam logic [1:0] CFG_DECAY        = 2'd1;
    localparam logic [1:0] CFG_KERNEL_FIRST = 2'd2;
    localparam logic [1:0] CFG_GUT_GAIN     = 2'd3;

    // Program steps
    typedef logic [3:0] t_step;
    localparam t_step STEP_WAIT   = 4'd0;
    localparam t_step STEP_MAC    = 4'd1;
    localparam t_step STEP_DRAIN0 = 4'd2;
    localparam t_step STEP_DRAIN1 = 4'd3;
    localparam t_step STEP_DRAIN2 = 4'd4;
    localparam t_step STEP_SATU   = 4'd5;
    localparam t_step STEP_MULF   = 4'd6;
    localparam t_step STEP_MULG   = 4'd7;
    localparam t_step STEP_MULD   = 4'd8;
    localparam t_step STEP_CAPD   = 4'd9;
    localparam t_step STEP_UPD    = 4'd10;
    localparam t_step STEP_SETF   = 4'd11;
    localparam t_step STEP_MULS   = 4'd12;
    localparam t_step STEP_SETRA  = 4'd13;
    localparam t_step STEP_OUT    = 4'd14;

    typedef enum logic [2:0] {
        MUL_NONE, MUL_FMAG, MUL_GAIN, MUL_DMAG, MUL_FPOS
    } t_mul_sel;

    typedef enum logic [3:0] {
        UOP_NOP, UOP_SATU, UOP_CAPFQ, UOP_CAPGIN, UOP_CAPDQ,
        UOP_UPD, UOP_SETF, UOP_SETRA, UOP_OUT
    } t_uop;

    typedef enum logic [2:0] {
        JC_NEXT, JC_NO_BEAT, JC_MORE_TAPS, JC_START, JC_ALWAYS, JC_OUT_BUSY
    } t_jcond;

    typedef struct packed {
        logic     take_input;
        logic     issue;
        t_mul_sel mul_sel;
        t_uop     uop;
        t_jcond   jcond;
        t_step    target;
    } t_uword;

    // Control store
    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w = '{take_input: 1'b0, issue: 1'b0, mul_sel: MUL_NONE,
              uop: UOP_NOP, jcond: JC_NEXT, target: STEP_WAIT};
        unique case (step)
            STEP_WAIT: begin
                w.take_input = 1'b1;
                w.jcond      = JC_NO_BEAT;
                w.target     = STEP_WAIT;
            end
            STEP_MAC: begin
                w.issue  = 1'b1;
                w.jcond  = JC_MORE_TAPS;
                w.target = STEP_MAC;
            end
            STEP_DRAIN0, STEP_DRAIN1, STEP_DRAIN2: begin
                w.uop = UOP_NOP;
            end
            STEP_SATU: begin
                w.uop    = UOP_SATU;
                w.jcond  = JC_START;
                w.target = STEP_SETF;
            end
            STEP_MULF: begin
                w.mul_sel = MUL_FMAG;
            end
            STEP_MULG: begin
                w.uop     = UOP_CAPFQ;
                w.mul_sel = MUL_GAIN;
            end
            STEP_MULD: begin
                w.uop     = UOP_CAPGIN;
                w.mul_sel = MUL_DMAG;
            end
            STEP_CAPD: begin
                w.uop = UOP_CAPDQ;
            end
            STEP_UPD: begin
                w.uop    = UOP_UPD;
                w.jcond  = JC_ALWAYS;
                w.target = STEP_OUT;
            end
            STEP_SETF: begin
                w.uop = UOP_SETF;
            end
            STEP_MULS: begin
                w.mul_sel = MUL_FPOS;
            end
            STEP_SETRA: begin
                w.uop = UOP_SETRA;
            end
            STEP_OUT: begin
                w.uop    = UOP_OUT;
                w.jcond  = JC_OUT_BUSY;
                w.target = STEP_OUT;
            end
            default: begin
                w.jcond  = JC_ALWAYS;
                w.target = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic [49:0] v);
        logic [31:0] r;
        r = v[31:0];
        if (!v[49] && (|v[48:31])) begin
            r = 32'h7FFF_FFFF;
        end else if (v[49] && !(&v[48:31])) begin
            r = 32'h8000_0000;
        end
        return r;
    endfunction

    // Configuration registers
    logic [31:0] r_inv_peak, r_decay, r_kernel_first, r_gut_gain;

    // Sequencer state
    t_step       r_step, n_step;
    t_uword      uword;
    logic        r_first, r_start, r_ovalid;
    logic        in_beat, out_busy, jump;

    // Stage datapath
    logic [31:0] r_u_new, r_u_prev, r_f, r_ra, r_fmag, r_fq;
    logic [32:0] r_dmag, r_dq;
    logic        r_fneg, r_dneg;
    logic [47:0] r_gin;
    logic [64:0] r_mprod;
    logic [95:0] r_odata;
    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [32:0] fr_diff;
    logic [49:0] fq_s, dq_s, f_sum, ra_sum;

    // Convolution unit
    t_mac_ctl    mac_ctl;
    logic        mac_last;
    logic [31:0] mac_rate;

    assign uword         = ucode(r_step);
    assign s_axis_tready = uword.take_input;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_busy      = r_ovalid && !m_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    assign mac_ctl.load  = in_beat;
    assign mac_ctl.start = s_axis_tuser[0] || r_first;
    assign mac_ctl.issue = uword.issue;

    gam_mac u_mac (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (mac_ctl),
        .i_intake       (s_axis_tdata),
        .i_kernel_first (r_kernel_first),
        .i_decay_ratio  (r_decay),
        .o_last_tap     (mac_last),
        .o_rate         (mac_rate)
    );

    // Branch decision and next step
    always_comb begin
        case (uword.jcond)
            JC_NO_BEAT:   jump = !in_beat;
            JC_MORE_TAPS: jump = !mac_last;
            JC_START:     jump = r_start;
            JC_ALWAYS:    jump = 1'b1;
            JC_OUT_BUSY:  jump = out_busy;
            default:      jump = 1'b0;
        endcase
        if (jump) begin
            n_step = uword.target;
        end else if (r_step == STEP_OUT) begin
            n_step = STEP_WAIT;
        end else begin
            n_step = r_step + 4'd1;
        end
    end

    // Sequencer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= STEP_WAIT;
            r_first  <= 1'b1;
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (in_beat) begin
                r_start <= mac_ctl.start;
                r_first <= 1'b0;
            end
            if (uword.uop == UOP_OUT && !out_busy) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_peak     <= 32'd1489198000;
            r_decay        <= 32'd3036701000;
            r_kernel_first <= 32'd10356;
            r_gut_gain     <= 32'd42243;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_INV_PEAK:     r_inv_peak     <= i_cfg_data;
                CFG_DECAY:        r_decay        <= i_cfg_data;
                CFG_KERNEL_FIRST: r_kernel_first <= i_cfg_data;
                CFG_GUT_GAIN:     r_gut_gain     <= i_cfg_data;
                default:          r_inv_peak     <= r_inv_peak;
            endcase
        end
    end

    // Shared multiplier operand select
    always_comb begin
        case (uword.mul_sel)
            MUL_FMAG: begin mul_a = {1'b0, r_fmag};     mul_b = r_inv_peak; end
            MUL_GAIN: begin mul_a = {1'b0, r_gut_gain}; mul_b = r_u_prev;   end
            MUL_DMAG: begin mul_a = r_dmag;             mul_b = r_inv_peak; end
            MUL_FPOS: begin mul_a = {1'b0, r_f};        mul_b = r_inv_peak; end
            default:  begin mul_a = '0;                 mul_b = '0;         end
        endcase
    end

    // Stage arithmetic
    assign fr_diff = {r_f[31], r_f} - {r_ra[31], r_ra};
    assign fq_s    = r_fneg ? -{18'd0, r_fq} : {18'd0, r_fq};
    assign dq_s    = r_dneg ? -{17'd0, r_dq} : {17'd0, r_dq};
    assign f_sum   = {{18{r_f[31]}}, r_f} - fq_s + {2'd0, r_gin};
    assign ra_sum  = {{18{r_ra[31]}}, r_ra} + dq_s;

    // Datapath registers driven by the micro-op
    always_ff @(posedge i_clk) begin
        if (uword.mul_sel != MUL_NONE) begin
            r_mprod <= mul_a * mul_b;
        end
        case (uword.uop)
            UOP_SATU: begin
                r_u_new <= mac_rate;
                r_fneg  <= r_f[31];
                r_fmag  <= r_f[31] ? -r_f : r_f;
                r_dneg  <= fr_diff[32];
                r_dmag  <= fr_diff[32] ? -fr_diff : fr_diff;
            end
            UOP_CAPFQ:  r_fq  <= r_mprod[63:32];
            UOP_CAPGIN: r_gin <= r_mprod[63:16];
            UOP_CAPDQ:  r_dq  <= r_mprod[64:32];
            UOP_UPD: begin
                r_f      <= sat32(f_sum);
                r_ra     <= sat32(ra_sum);
                r_u_prev <= r_u_new;
            end
            UOP_SETF: r_f <= r_u_new[31] ? 32'h7FFF_FFFF : r_u_new;
            UOP_SETRA: begin
                r_ra     <= r_mprod[63:32];
                r_u_prev <= r_u_new;
            end
            UOP_OUT: begin
                if (!out_busy) begin
                    r_odata <= {r_u_prev, r_f, r_ra};
                end
            end
            default: r_fq <= r_fq;
        endcase
    end

    // Checks
    a_beat_starts_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> (r_step == STEP_MAC))
        else $error("input beat did not start the tap loop");

    a_out_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_OUT && !out_busy) |=> m_axis_tvalid)
        else $error("result slot free but no result presented");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_step) == STEP_OUT))
        else $error("result raised outside the output step");

endmodule

// ----- tb/glucose_absorption_model_step_tb.sv -----
// ----------------------------------------------------------------------------
// glucose_absorption_model_step_tb: self-checking bench for the meal step
// Streams carbohydrate intakes through the block and scores every result beat
// against a cycle-free software copy of the convolution and both gut stages.
// Registers are rewritten between phases (defaults, all-ones, all-zeros,
// random), and the source and sink throttle at random per phase.
// ----------------------------------------------------------------------------
module glucose_absorption_model_step_tb import gam_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // Register map of the configuration channel
    typedef enum logic [1:0] {
        REG_INV_PEAK_TIME = 2'd0,
        REG_DECAY_RATIO   = 2'd1,
        REG_KERNEL_FIRST  = 2'd2,
        REG_GUT_GAIN      = 2'd3
    } reg_index_e;

    typedef struct packed {
        reg_index_e  reg_sel;
        logic [31:0] value;
    } reg_write_t;

    typedef struct packed {
        logic        restart;
        logic [31:0] intake;
    } intake_beat_t;

    // Same layout as m_axis_tdata: Ra low, F middle, U high
    typedef struct packed {
        logic [31:0]        meal_rate;
        logic signed [31:0] gut_amount;
        logic signed [31:0] appearance_rate;
    } absorb_result_t;

    localparam int     IDLE_LIMIT = 4000;  // cycles without any beat
    localparam int     DRAIN_WAIT = 320;   // idle wait before the final check
    localparam longint S32_MAX    = 64'sd2147483647;
    localparam longint S32_MIN    = -64'sd2147483648;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports
    // ------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = '0;
    logic [31:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [31:0] carb_intake
    logic [0:0]  s_axis_tuser  = '0;   // [0] restart_record
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;         // [31:0] Ra, [63:32] F, [95:64] U

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    glucose_absorption_model_step dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------
    intake_beat_t   pending_beats[$];
    reg_write_t     pending_writes[$];
    absorb_result_t expected_results[$];
    int beats_queued    = 0;
    int beats_taken     = 0;
    int writes_queued   = 0;
    int writes_taken    = 0;
    int mismatches      = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int record_left     = 0;
    bit long_record_due = 1'b1;

    // Predictor copy of registers and state, at reset values
    bit [31:0] inv_peak_q     = 32'd1489198000;
    bit [31:0] decay_q        = 32'd3036701000;
    bit [31:0] kernel_first_q = 32'd10356;
    bit [31:0] gut_gain_q     = 32'd42243;
    bit [31:0] intake_ring [KERNEL_TAPS];
    int        ring_ptr       = 0;
    longint    gut_f          = 0;
    longint    gut_ra         = 0;
    bit [31:0] prev_u         = '0;
    bit        first_flag     = 1'b1;

    initial foreach (intake_ring[i]) intake_ring[i] = '0;

    // ------------------------------------------------------------------
    // Arithmetic helpers
    // ------------------------------------------------------------------
    function automatic longint clamp_s32(longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    // a * k / 2^32 truncated toward zero
    function automatic longint scale_q32(longint a, bit [31:0] k);
        bit [63:0] mag;
        bit [63:0] prod;
        mag  = (a < 0) ? 64'(-a) : 64'(a);
        prod = (mag * 64'(k)) >> 32;
        return (a < 0) ? -$signed(prod) : $signed(prod);
    endfunction

    // One absorption tick: store the intake, convolve, advance F and Ra
    function automatic absorb_result_t predict_absorption(bit [31:0] intake, bit restart);
        absorb_result_t res;
        bit [63:0]      acc;
        bit [63:0]      tap;
        bit [31:0]      u;
        int             slot;
        int             d;
        bit             new_record;
        longint         gin;
        longint         f_next;
        longint         ra_next;
        new_record = restart || first_flag;
        if (new_record) begin
            foreach (intake_ring[i]) intake_ring[i] = '0;
            ring_ptr = 0;
        end
        intake_ring[ring_ptr] = intake;

        // Truncated convolution with the geometric kernel
        acc  = '0;
        tap  = 64'(kernel_first_q);
        slot = ring_ptr;
        for (d = 0; d < KERNEL_TAPS; d++) begin
            acc += (64'(intake_ring[slot]) * tap) >> 16;
            tap  = (tap * 64'(decay_q)) >> 32;
            slot = (slot == 0) ? KERNEL_TAPS - 1 : slot - 1;
        end
        u = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];

        // Gut and appearance stages
        if (new_record) begin
            f_next  = clamp_s32($signed(64'(u)));
            ra_next = clamp_s32(scale_q32(f_next, inv_peak_q));
        end else begin
            gin     = $signed((64'(gut_gain_q) * 64'(prev_u)) >> 16);
            f_next  = clamp_s32(gut_f - scale_q32(gut_f, inv_peak_q) + gin);
            ra_next = clamp_s32(gut_ra + scale_q32(gut_f - gut_ra, inv_peak_q));
        end

        gut_f      = f_next;
        gut_ra     = ra_next;
        prev_u     = u;
        first_flag = 1'b0;
        ring_ptr   = (ring_ptr + 1 >= KERNEL_TAPS) ? 0 : ring_ptr + 1;

        res.appearance_rate = ra_next[31:0];
        res.gut_amount      = f_next[31:0];
        res.meal_rate       = u;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: predicts on each accepted beat, then refills
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_intake
        intake_beat_t nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(predict_absorption(s_axis_tdata, s_axis_tuser[0]));
                beats_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.intake;
                    s_axis_tuser  <= nxt.restart;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Register write driver: mirrors each accepted write into the predictor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_config
        reg_write_t wr;
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (reg_index_e'(i_cfg_index))
                    REG_INV_PEAK_TIME: inv_peak_q     = i_cfg_data;
                    REG_DECAY_RATIO:   decay_q        = i_cfg_data;
                    REG_KERNEL_FIRST:  kernel_first_q = i_cfg_data;
                    REG_GUT_GAIN:      gut_gain_q     = i_cfg_data;
                    default: ;
                endcase
                writes_taken++;
            end
            if (!i_cfg_valid || o_cfg_ready) begin
                if (pending_writes.size() != 0) begin
                    wr = pending_writes.pop_front();
                    i_cfg_valid <= 1'b1;
                    i_cfg_index <= wr.reg_sel;
                    i_cfg_data  <= wr.value;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Result backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= i_rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Result monitor: in-order compare against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : score_result
        absorb_result_t got;
        absorb_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_results.size() == 0) begin
                $error("unexpected result beat: %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (got.appearance_rate !== want.appearance_rate) begin
                    $error("appearance_rate: expected %0d, got %0d",
                           want.appearance_rate, got.appearance_rate);
                    mismatches++;
                end
                if (got.gut_amount !== want.gut_amount) begin
                    $error("gut_amount: expected %0d, got %0d",
                           want.gut_amount, got.gut_amount);
                    mismatches++;
                end
                if (got.meal_rate !== want.meal_rate) begin
                    $error("meal_input_rate: expected %h, got %h",
                           want.meal_rate, got.meal_rate);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog on stalled traffic
    // ------------------------------------------------------------------
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers (run on the falling edge)
    // ------------------------------------------------------------------
    task automatic queue_beat(logic [31:0] intake, logic restart);
        intake_beat_t b;
        b.intake  = intake;
        b.restart = restart;
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    task automatic queue_write(reg_index_e sel, logic [31:0] value);
        reg_write_t w;
        w.reg_sel = sel;
        w.value   = value;
        pending_writes.push_back(w);
        writes_queued++;
    endtask

    // Wait until every beat, write and result has gone through
    task automatic settle();
        while (beats_taken != beats_queued || writes_taken != writes_queued ||
               expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_all(logic [31:0] inv, logic [31:0] dec, logic [31:0] kf,
                             logic [31:0] gg);
        settle();
        queue_write(REG_INV_PEAK_TIME, inv);
        queue_write(REG_DECAY_RATIO, dec);
        queue_write(REG_KERNEL_FIRST, kf);
        queue_write(REG_GUT_GAIN, gg);
        settle();
    endtask

    // Plausible absorption constants most of the time, raw words otherwise
    task automatic write_random_settings();
        logic [31:0] inv, dec, kf, gg;
        inv = ($urandom_range(0, 1) == 0) ? $urandom_range(32'h2000_0000, 32'h8000_0000)
                                          : $urandom;
        dec = ($urandom_range(0, 1) == 0) ? $urandom_range(32'hA000_0000, 32'hF800_0000)
                                          : $urandom;
        case ($urandom_range(0, 3))
            0, 1:    kf = $urandom_range(0, 32'h0000_8000);
            2:       kf = $urandom_range(0, 32'h0010_0000);
            default: kf = $urandom;
        endcase
        gg = ($urandom_range(0, 4) < 3) ? $urandom_range(0, 32'h0002_0000) : $urandom;
        write_all(inv, dec, kf, gg);
    endtask

    // Records of meals: mostly empty ticks, some meals, rare raw words,
    // with the odd restart thrown in mid-record
    task automatic queue_records(int count);
        logic [31:0] intake;
        logic        restart;
        int          pick;
        repeat (count) begin
            if (record_left == 0) begin
                restart = 1'b1;
                if (long_record_due)
                    record_left = 330;  // long enough to wrap the history ring
                else if ($urandom_range(0, 5) == 0)
                    record_left = $urandom_range(250, 400);
                else
                    record_left = $urandom_range(1, 60);
                long_record_due = 1'b0;
            end else begin
                restart = ($urandom_range(0, 99) < 3);
            end
            record_left--;
            pick = $urandom_range(0, 99);
            if (pick < 85)      intake = '0;
            else if (pick < 95) intake = $urandom_range(0, 32'h0064_0000);
            else                intake = $urandom;
            queue_beat(intake, restart);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset defaults: first sample after reset, decay, big intake,
        // restart in mid-record
        queue_beat(32'h0001_0000, 1'b0);
        queue_beat(32'h0000_0000, 1'b0);
        queue_beat(32'h0000_0000, 1'b0);
        queue_beat(32'hFFFF_FFFF, 1'b0);
        queue_beat(32'h0000_0000, 1'b0);
        queue_beat(32'h0002_0000, 1'b1);
        queue_beat(32'h0000_0001, 1'b0);
        queue_beat(32'hFFFF_FFFF, 1'b1);
        queue_beat(32'h0000_0000, 1'b0);

        // All ones: saturated sum, saturated initial gut amount
        write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_beat(32'hFFFF_FFFF, 1'b1);
        queue_beat(32'hFFFF_FFFF, 1'b0);
        queue_beat(32'h0000_0000, 1'b0);
        queue_beat(32'h0000_0001, 1'b0);
        queue_beat(32'h8000_0000, 1'b1);

        // All zeros: no kernel, frozen stages
        write_all('0, '0, '0, '0);
        queue_beat(32'hFFFF_FFFF, 1'b0);
        queue_beat(32'h0000_0000, 1'b0);
        queue_beat(32'h1234_5678, 1'b1);
        queue_beat(32'h0000_0000, 1'b0);

        // Back to realistic constants before the random run
        write_all(32'd1489198000, 32'd3036701000, 32'd10356, 32'd42243);
        queue_beat(32'h0003_0000, 1'b1);
        queue_beat(32'h0000_0000, 1'b0);
        settle();

        // Random phases, each with its own settings and throttling
        for (int phase = 0; phase < 4; phase++) begin
            if (phase != 0) write_random_settings();
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
            endcase
            queue_records(135);
            settle();
        end

        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
